// ===== hdl/polyline_chord_resampler_macros.svh =====
// assertion macros shared by the checker
`ifndef POLYLINE_CHORD_RESAMPLER_MACROS_SVH
`define POLYLINE_CHORD_RESAMPLER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define PCR_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pcr assertion failed");

// next-cycle implication
`define PCR_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pcr assertion failed");

`endif

// ===== hdl/pcr_pkg.sv =====
package pcr_pkg;

  localparam int BISECT_STEPS = 22;
  localparam int CORDIC_ITERS = 17;
  localparam int QUEUE_DEPTH  = 2;
  localparam int MAX_RESULTS  = 64;

  localparam logic [23:0] FRAC_ONE  = 24'h80_0000;
  localparam logic [23:0] FRAC_HALF = 24'h40_0000;
  localparam logic signed [19:0] QUARTER_TURN = 20'sd102944;
  localparam logic signed [15:0] HEADING_LIMIT = 16'sd25736;

  // configuration register indexes
  localparam logic REG_CHORD_LENGTH  = 1'b0;
  localparam logic REG_MAX_PER_POINT = 1'b1;

  // one queued point, start marks the opening point of a polyline
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               start;
  } item_t;

  typedef struct packed {
    logic               truncated;
    logic               last;
    logic signed [16:0] heading_change;
    logic signed [31:0] start_y;
    logic signed [31:0] start_x;
  } result_t;

  // arctangent of 2^-i in Q16 radians
  function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
    logic signed [19:0] r;
    unique case (i)
      5'd0:  r = 20'sd51472;
      5'd1:  r = 20'sd30386;
      5'd2:  r = 20'sd16055;
      5'd3:  r = 20'sd8150;
      5'd4:  r = 20'sd4091;
      5'd5:  r = 20'sd2047;
      5'd6:  r = 20'sd1024;
      5'd7:  r = 20'sd512;
      5'd8:  r = 20'sd256;
      5'd9:  r = 20'sd128;
      5'd10: r = 20'sd64;
      5'd11: r = 20'sd32;
      5'd12: r = 20'sd16;
      5'd13: r = 20'sd8;
      5'd14: r = 20'sd4;
      5'd15: r = 20'sd2;
      5'd16: r = 20'sd1;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/polyline_chord_resampler.sv =====
// Polyline chord resampler: points enter on the slave stream, one chord per
// master request. A point that opens a polyline emits nothing; a point closing
// a segment runs the end test, then per chord up to BisectSteps bisection
// steps (multiply, add, difference, square, compare through the one distance
// unit), the serial CORDIC heading, the next end test and the emit state. A
// two-entry queue lets new points arrive while a segment is being walked.
module polyline_chord_resampler #(
  parameter int BisectSteps = pcr_pkg::BISECT_STEPS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // point_x, point_y
  input  logic        s_axis_tuser,   // new_polyline
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // start_x, start_y, heading_change, zero fill
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // truncated
);

  logic             push, full, q_valid, pop;
  pcr_pkg::item_t   f_item, q_item;
  pcr_pkg::result_t res;

  pcr_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .push_o(push), .item_o(f_item), .full_i(full)
  );

  pcr_fifo #(.Depth(pcr_pkg::QUEUE_DEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(f_item), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .item_o(q_item)
  );

  pcr_back #(.BisectSteps(BisectSteps)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .item_valid_i(q_valid), .item_i(q_item), .item_pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tdata = {7'd0, res.heading_change, res.start_y, res.start_x};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.truncated;

endmodule

// ===== hdl/pcr_fifo.sv =====
module pcr_fifo #(
  parameter int Depth = pcr_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcr_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pcr_pkg::item_t  item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  pcr_pkg::item_t        mem_q [Depth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;

  assign full_o  = (cnt_q == ($clog2(Depth+1))'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pcr_front.sv =====
module pcr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,
  input  logic                s_axis_tuser,
  output logic                push_o,
  output pcr_pkg::item_t      item_o,
  input  logic                full_i
);

  logic have_prev_q;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // classify: a polyline opens on request or on the first point after reset
  assign item_o.x     = $signed(s_axis_tdata[31:0]);
  assign item_o.y     = $signed(s_axis_tdata[63:32]);
  assign item_o.start = s_axis_tuser || !have_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else if (push_o) begin
      have_prev_q <= 1'b1;
    end
  end

endmodule

// ===== hdl/pcr_back.sv =====
module pcr_back #(
  parameter int BisectSteps = pcr_pkg::BISECT_STEPS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [30:0]       cfg_data_i,
  input  logic              item_valid_i,
  input  pcr_pkg::item_t    item_i,
  output logic              item_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pcr_pkg::result_t  out_o
);

  localparam int IterW = $clog2(BisectSteps + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_CMP, S_MUL, S_ADD, S_HINIT, S_HITER, S_HEND, S_EMIT
  } state_e;

  state_e state_q;
  logic [30:0] chord_q;
  logic [6:0]  maxpp_q;
  logic [61:0] l2_q;
  logic signed [31:0] px_q, py_q, prev_x_q, prev_y_q, walk_x_q, walk_y_q, ex_q, ey_q;
  logic signed [32:0] dx_q, dy_q;
  logic [31:0] magx_q, magy_q;
  logic [63:0] sqx_q, sqy_q;
  logic signed [57:0] mx_q, my_q;
  logic [23:0] f_q, step_q;
  logic [IterW-1:0] it_q;
  logic [6:0]  n_q, cap_q;
  logic        probe_q;
  logic signed [35:0] hx_q, hy_q;
  logic signed [19:0] hz_q;
  logic [4:0]  hi_q;
  logic signed [15:0] hdg_q;
  pcr_pkg::result_t pend_q, out_q;
  logic        out_valid_q;

  // distance operands and compare
  logic signed [31:0] opx, opy;
  logic signed [32:0] ddx, ddy;
  logic [64:0] dsum;
  logic        d_gt, d_eq;
  // bisection update
  logic [23:0] half;
  logic signed [25:0] fsum;
  logic [23:0] f_new;
  // cordic step
  logic signed [35:0] xs, ys, hx0, hy0;
  // heading result
  logic signed [19:0] zr;
  logic signed [15:0] theta;
  logic signed [57:0] tx, ty;
  logic        done_c, last_c;

  assign item_pop_o  = (state_q == S_IDLE) && item_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign opx  = probe_q ? ex_q : px_q;
  assign opy  = probe_q ? ey_q : py_q;
  assign ddx  = 33'(opx) - 33'(walk_x_q);
  assign ddy  = 33'(opy) - 33'(walk_y_q);
  assign dsum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign d_gt = dsum > {3'b000, l2_q};
  assign d_eq = dsum == {3'b000, l2_q};

  always_comb begin
    half = step_q >> 1;
    if (d_gt) begin
      fsum = $signed({2'b00, f_q}) - $signed({2'b00, half});
    end else begin
      fsum = $signed({2'b00, f_q}) + $signed({2'b00, half});
    end
    if (fsum < 0) begin
      f_new = '0;
    end else if (fsum > $signed({2'b00, pcr_pkg::FRAC_ONE})) begin
      f_new = pcr_pkg::FRAC_ONE;
    end else begin
      f_new = fsum[23:0];
    end
  end

  assign xs  = hx_q >>> hi_q;
  assign ys  = hy_q >>> hi_q;
  assign hx0 = 36'(33'(ex_q) - 33'(walk_x_q));
  assign hy0 = 36'(33'(ey_q) - 33'(walk_y_q));
  assign tx  = mx_q + 58'(pcr_pkg::FRAC_HALF);
  assign ty  = my_q + 58'(pcr_pkg::FRAC_HALF);

  // round Q16 to Q3.13 and clamp
  always_comb begin
    zr = (hz_q + 20'sd4) >>> 3;
    if (zr > 20'(pcr_pkg::HEADING_LIMIT)) begin
      theta = pcr_pkg::HEADING_LIMIT;
    end else if (zr < -20'(pcr_pkg::HEADING_LIMIT)) begin
      theta = -pcr_pkg::HEADING_LIMIT;
    end else begin
      theta = zr[15:0];
    end
  end

  assign done_c = !d_gt || f_q[23];
  assign last_c = done_c || (n_q == cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chord_q     <= 31'd65536;
      maxpp_q     <= 7'd1;
      l2_q        <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      hdg_q       <= '0;
      f_q         <= pcr_pkg::FRAC_HALF;
      out_valid_q <= 1'b0;
      probe_q     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        if (cfg_index_i == pcr_pkg::REG_CHORD_LENGTH) begin
          chord_q <= cfg_data_i;
        end else begin
          maxpp_q <= cfg_data_i[6:0];
        end
      end
      l2_q <= 62'(chord_q) * 62'(chord_q);

      // output register drains; the emit state refills it itself
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        // take the next point
        S_IDLE: begin
          if (item_valid_i) begin
            if (item_i.start) begin
              prev_x_q <= item_i.x;
              prev_y_q <= item_i.y;
              walk_x_q <= item_i.x;
              walk_y_q <= item_i.y;
              hdg_q    <= '0;
              f_q      <= pcr_pkg::FRAC_HALF;
            end else begin
              px_q    <= item_i.x;
              py_q    <= item_i.y;
              dx_q    <= 33'(item_i.x) - 33'(prev_x_q);
              dy_q    <= 33'(item_i.y) - 33'(prev_y_q);
              n_q     <= '0;
              probe_q <= 1'b0;
              if (maxpp_q == 7'd0) begin
                cap_q <= 7'd1;
              end else if (maxpp_q > 7'(pcr_pkg::MAX_RESULTS)) begin
                cap_q <= 7'(pcr_pkg::MAX_RESULTS);
              end else begin
                cap_q <= maxpp_q;
              end
              state_q <= S_DIFF;
            end
          end
        end
        // distance magnitudes
        S_DIFF: begin
          magx_q  <= ddx[32] ? 32'(-ddx) : ddx[31:0];
          magy_q  <= ddy[32] ? 32'(-ddy) : ddy[31:0];
          state_q <= S_SQ;
        end
        S_SQ: begin
          sqx_q   <= 64'(magx_q) * 64'(magx_q);
          sqy_q   <= 64'(magy_q) * 64'(magy_q);
          state_q <= S_CMP;
        end
        // compare against chord length squared
        S_CMP: begin
          if (probe_q) begin
            if (d_eq) begin
              state_q <= S_HINIT;
            end else begin
              f_q    <= f_new;
              step_q <= half;
              it_q   <= it_q + 1'b1;
              state_q <= (it_q + 1'b1 == IterW'(BisectSteps)) ? S_HINIT : S_MUL;
            end
          end else if (n_q == '0) begin
            if (!d_gt) begin
              prev_x_q <= px_q;
              prev_y_q <= py_q;
              f_q      <= pcr_pkg::FRAC_HALF;
              state_q  <= S_IDLE;
            end else begin
              step_q  <= pcr_pkg::FRAC_ONE - f_q;
              it_q    <= '0;
              probe_q <= 1'b1;
              state_q <= S_MUL;
            end
          end else begin
            pend_q.last      <= last_c;
            pend_q.truncated <= last_c && !done_c;
            state_q          <= S_EMIT;
          end
        end
        // probe point on the segment
        S_MUL: begin
          mx_q    <= dx_q * $signed({1'b0, f_q});
          my_q    <= dy_q * $signed({1'b0, f_q});
          state_q <= S_ADD;
        end
        S_ADD: begin
          ex_q    <= prev_x_q + 32'(tx >>> 23);
          ey_q    <= prev_y_q + 32'(ty >>> 23);
          state_q <= S_DIFF;
        end
        // heading: quarter-turn pre-rotation
        S_HINIT: begin
          hi_q <= '0;
          if (hx0 == '0 && hy0 == '0) begin
            hz_q    <= '0;
            state_q <= S_HEND;
          end else begin
            if (hx0 < 0) begin
              if (!hy0[35]) begin
                hx_q <= hy0;
                hy_q <= -hx0;
                hz_q <= pcr_pkg::QUARTER_TURN;
              end else begin
                hx_q <= -hy0;
                hy_q <= hx0;
                hz_q <= -pcr_pkg::QUARTER_TURN;
              end
            end else begin
              hx_q <= hx0;
              hy_q <= hy0;
              hz_q <= '0;
            end
            state_q <= S_HITER;
          end
        end
        // one cordic vectoring step a cycle
        S_HITER: begin
          if (!hy_q[35]) begin
            hx_q <= hx_q + ys;
            hy_q <= hy_q - xs;
            hz_q <= hz_q + pcr_pkg::atan_q16(hi_q);
          end else begin
            hx_q <= hx_q - ys;
            hy_q <= hy_q + xs;
            hz_q <= hz_q - pcr_pkg::atan_q16(hi_q);
          end
          hi_q <= hi_q + 1'b1;
          if (hi_q == 5'(pcr_pkg::CORDIC_ITERS - 1)) begin
            state_q <= S_HEND;
          end
        end
        // chord found: record it and move the walk point
        S_HEND: begin
          pend_q.start_x        <= walk_x_q;
          pend_q.start_y        <= walk_y_q;
          pend_q.heading_change <= 17'(theta) - 17'(hdg_q);
          hdg_q    <= theta;
          walk_x_q <= ex_q;
          walk_y_q <= ey_q;
          n_q      <= n_q + 1'b1;
          probe_q  <= 1'b0;
          state_q  <= S_DIFF;
        end
        // hand the chord to the output register
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            if (pend_q.last) begin
              prev_x_q <= px_q;
              prev_y_q <= py_q;
              f_q      <= pcr_pkg::FRAC_HALF;
              state_q  <= S_IDLE;
            end else begin
              step_q  <= pcr_pkg::FRAC_ONE - f_q;
              it_q    <= '0;
              probe_q <= 1'b1;
              state_q <= S_MUL;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/pcr_checker.sv =====
`include "polyline_chord_resampler_macros.svh"

module pcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // a stalled chord holds
  `PCR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // truncation is only flagged on the final chord of a point
  `PCR_ASSERT_IMP(a_trunc_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  // heading change stays within twice the heading limit
  `PCR_ASSERT_IMP(a_hdg_range, m_axis_tvalid, ($signed(m_axis_tdata[80:64]) <= 17'sd51472) && ($signed(m_axis_tdata[80:64]) >= -17'sd51472))
  // fill bits stay zero
  `PCR_ASSERT_IMP(a_fill_zero, m_axis_tvalid, m_axis_tdata[87:81] == 7'd0)

endmodule

bind polyline_chord_resampler pcr_checker u_pcr_checker (.*);

// ===== test/polyline_chord_resampler_tb.sv =====
`timescale 1ns / 1ps

module polyline_chord_resampler_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [30:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // point_x, point_y
  logic        s_axis_tuser = 1'b0; // new_polyline
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // start_x, start_y, heading_change, zero fill
  logic        m_axis_tlast;
  logic        m_axis_tuser;        // truncated

  polyline_chord_resampler dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state and its copy of the registers
  longint unsigned chord_len;
  int              chord_cap;
  bit              have_prev;
  longint          prev_x, prev_y, walk_x, walk_y, prev_heading, seg_frac;

  pcr_pkg::result_t chords_due[$];
  int      errors = 0;
  int      gap_pct = 0;
  int      rx_stall_pct = 0;
  int      quiet_cycles = 0;

  // -1, 0, 1 as the distance a..b is below, at, above len
  function automatic int dist_cmp(longint ax, longint ay, longint bx, longint by,
                                  longint unsigned len);
    longint          dx, dy;
    longint unsigned mx, my, sx, sy, s, l2;
    dx = ax - bx;
    dy = ay - by;
    mx = (dx < 0) ? longint'(-dx) : longint'(dx);
    my = (dy < 0) ? longint'(-dy) : longint'(dy);
    sx = mx * mx;
    sy = my * my;
    s  = sx + sy;
    l2 = len * len;
    if (s < sx || s > l2) return 1;
    return (s < l2) ? -1 : 0;
  endfunction

  // cordic vectoring heading in Q3.13
  function automatic longint heading_q13(longint dx, longint dy);
    longint x, y, z, t, xs, ys, r;
    longint atan_tab [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                              128, 64, 32, 16, 8, 4, 2, 1};
    x = dx; y = dy; z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 102944;
      end else begin
        x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    r = (z + 4) >>> 3;
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r;
  endfunction

  // walk one point and queue the chords it produces
  function automatic void walk_point(logic signed [31:0] px_in, logic signed [31:0] py_in,
                                     bit fresh);
    longint  px, py, dx, dy, f, stp, ex, ey, theta;
    int      cap, n, c;
    bit      done;
    pcr_pkg::result_t r;
    px = px_in; py = py_in;
    dx = px - prev_x; dy = py - prev_y;
    n = 0;
    if (fresh || !have_prev) begin
      prev_x = px; walk_x = px; prev_y = py; walk_y = py;
      prev_heading = 0; seg_frac = longint'(pcr_pkg::FRAC_HALF); have_prev = 1;
      return;
    end
    cap = (chord_cap < 1) ? 1 :
          (chord_cap > pcr_pkg::MAX_RESULTS) ? pcr_pkg::MAX_RESULTS : chord_cap;
    done = dist_cmp(px, py, walk_x, walk_y, chord_len) <= 0;
    while (!done && n < cap) begin
      f = seg_frac; stp = longint'(pcr_pkg::FRAC_ONE) - f;
      ex = walk_x; ey = walk_y;
      for (int i = 0; i < pcr_pkg::BISECT_STEPS; i++) begin
        ex = prev_x + ((dx * f + longint'(pcr_pkg::FRAC_HALF)) >>> 23);
        ey = prev_y + ((dy * f + longint'(pcr_pkg::FRAC_HALF)) >>> 23);
        c = dist_cmp(ex, ey, walk_x, walk_y, chord_len);
        if (c == 0) break;
        f += (c < 0) ? (stp >>> 1) : -(stp >>> 1);
        stp = stp >>> 1;
        if (f < 0) f = 0;
        if (f > longint'(pcr_pkg::FRAC_ONE)) f = longint'(pcr_pkg::FRAC_ONE);
      end
      theta = heading_q13(ex - walk_x, ey - walk_y);
      r.start_x = walk_x[31:0];
      r.start_y = walk_y[31:0];
      r.heading_change = 17'(theta - prev_heading);
      r.last = 1'b0;
      r.truncated = 1'b0;
      chords_due = {chords_due, r};
      n++;
      prev_heading = theta;
      walk_x = ex; walk_y = ey; seg_frac = f;
      if (dist_cmp(px, py, walk_x, walk_y, chord_len) <= 0 ||
          f >= longint'(pcr_pkg::FRAC_ONE))
        done = 1;
    end
    if (n > 0) begin
      chords_due[$].last = 1'b1;
      chords_due[$].truncated = !done;
    end
    seg_frac = longint'(pcr_pkg::FRAC_HALF);
    prev_x = px; prev_y = py;
  endfunction

  // one point request, with random idle cycles ahead of it
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit fresh);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= fresh;
    do @(posedge clk_i); while (!s_axis_tready);
    walk_point(x, y, fresh);
  endtask

  // let the block drain before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (chords_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write enable is dropped by the caller after the last write
  task automatic write_reg(logic idx, logic [30:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    if (idx == pcr_pkg::REG_CHORD_LENGTH) chord_len = val;
    else chord_cap = val[6:0];
  endtask

  task automatic set_regs(logic [30:0] len, logic [30:0] cap);
    settle();
    write_reg(pcr_pkg::REG_CHORD_LENGTH, len);
    write_reg(pcr_pkg::REG_MAX_PER_POINT, cap);
    cfg_we_i <= 1'b0;
  endtask

  // reset values: first point without the new flag, short segment, capped walk
  task automatic test_reset_defaults();
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sd32768, 32'sd0, 1'b0);
    send_point(32'sd196608, 32'sd0, 1'b0);
    send_point(32'sd196608, 32'sd0, 1'b0);
  endtask

  // extremes of coordinates and registers, all four quadrants
  task automatic test_extremes();
    set_regs(31'h7fff_ffff, 31'd64);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    set_regs(31'd1, 31'd64);
    send_point(32'sd0, 32'sd0, 1'b1);
    send_point(32'sd10, 32'sd0, 1'b0);
    send_point(32'sd10, -32'sd7, 1'b0);
    send_point(-32'sd200, 32'sd3, 1'b0);
    set_regs(31'd65536, 31'd3);
    send_point(32'sd0, 32'sd0, 1'b1);
    send_point(-32'sd500000, 32'sd300000, 1'b0);
    send_point(-32'sd600000, -32'sd400000, 1'b0);
    send_point(32'sd200000, -32'sd500000, 1'b0);
    send_point(32'sd200000, -32'sd500000, 1'b1);
    send_point(32'sd250000, -32'sd500000, 1'b0);
  endtask

  // polylines with random content plus some raw noise
  task automatic test_random(int n_items, int gap, int stall,
                             logic [30:0] len, logic [30:0] cap);
    int     sent, pts;
    longint cx, cy, span;
    set_regs(len, cap);
    gap_pct = gap;
    rx_stall_pct = stall;
    sent = 0;
    span = longint'(len) * 6;
    while (sent < n_items) begin
      if (sent > n_items / 2 && sent < n_items / 2 + 10) begin
        // hold off until every chord so far is out
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (chords_due.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(99) < 8) begin
        send_point($urandom, $urandom, $urandom_range(1));
        sent++;
      end else begin
        cx = longint'($urandom_range(2097152)) - 1048576;
        cy = longint'($urandom_range(2097152)) - 1048576;
        send_point(cx[31:0], cy[31:0], 1'b1);
        pts = $urandom_range(8, 3);
        for (int i = 0; i < pts; i++) begin
          cx += longint'($urandom_range(32'(2 * span))) - span;
          cy += longint'($urandom_range(32'(2 * span))) - span;
          send_point(cx[31:0], cy[31:0], 1'b0);
        end
        sent += pts + 1;
      end
    end
    gap_pct = 0;
    rx_stall_pct = 0;
  endtask

  // receiver back-pressure
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

  // chord checker
  always @(posedge clk_i) begin
    pcr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (chords_due.size() == 0) begin
        $display("%0t: unexpected chord x=%h y=%h", $time,
                 m_axis_tdata[31:0], m_axis_tdata[63:32]);
        errors++;
      end else begin
        want = chords_due.pop_front();
        if (m_axis_tdata[31:0] !== want.start_x) begin
          $display("%0t: start_x expected %h actual %h", $time, want.start_x,
                   m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== want.start_y) begin
          $display("%0t: start_y expected %h actual %h", $time, want.start_y,
                   m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tdata[80:64] !== want.heading_change) begin
          $display("%0t: heading_change expected %h actual %h", $time,
                   want.heading_change, m_axis_tdata[80:64]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== want.truncated) begin
          $display("%0t: truncated expected %b actual %b", $time, want.truncated,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[polyline_chord_resampler] ERROR");
      $finish;
    end
  end

  initial begin
    chord_len = 65536;
    chord_cap = 1;
    have_prev = 0;
    prev_x = 0; prev_y = 0; walk_x = 0; walk_y = 0;
    prev_heading = 0;
    seg_frac = longint'(pcr_pkg::FRAC_HALF);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_random(105, 0, 0, 31'd65536, 31'd8);
    test_random(105, 81, 0, 31'd262144, 31'd64);
    test_random(105, 0, 81, 31'd5000, 31'd3);
    test_random(105, 6, 6, 31'd1048576, 31'd1);
    settle();
    if (errors == 0 && chords_due.size() == 0) begin
      $display("[polyline_chord_resampler] OK");
    end else begin
      if (chords_due.size() != 0)
        $display("%0t: %0d chords never arrived", $time, chords_due.size());
      $display("[polyline_chord_resampler] ERROR");
    end
    $finish;
  end

endmodule

// ===== polyline_chord_resampler.f =====
+incdir+hdl
hdl/pcr_pkg.sv
hdl/pcr_fifo.sv
hdl/pcr_front.sv
hdl/pcr_back.sv
hdl/polyline_chord_resampler.sv
hdl/pcr_checker.sv
test/polyline_chord_resampler_tb.sv
